// File: hw/rtl/glfs_pkg.sv
// shared types, codes and default sizes for the grid liquid flow block
package glfs_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;
    localparam int MAX_LEVEL_DEF   = 16;

    // three-way and two-way split of a liquid sum
    localparam int SPLIT_THREE = 3;
    localparam int SPLIT_TWO   = 2;

    localparam logic [1:0] TILE_AIR  = 2'd0;
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_READ_CAP,
        ST_OUT,
        ST_RD_C,
        ST_CHK,
        ST_GET_B,
        ST_GET_L,
        ST_GET_R,
        ST_ROOM,
        ST_MOVE,
        ST_FALL_B,
        ST_FALL_C,
        ST_SIDE,
        ST_SUM3,
        ST_DIV,
        ST_MUL3,
        ST_REM,
        ST_FIX,
        ST_FIX_Q,
        ST_SPLIT3,
        ST_PAIR,
        ST_WR_C,
        ST_WR_B,
        ST_WR_L,
        ST_WR_R,
        ST_NEXT,
        ST_FLAGS,
        ST_FLAGS_END
    } state_t;

endpackage

// File: hw/rtl/glfs_ram.sv
// generic single write, single read ram with registered read data
module glfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/glfs_alu.sv
// shared add, subtract and multiply unit for the flow sequencer
module glfs_alu #(
    parameter int W = 8
) (
    input  glfs_pkg::alu_op_t op,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output logic [2*W-1:0]    res
);

    always_comb begin
        case (op)
            glfs_pkg::ALU_ADD: res = {{W{1'b0}}, a} + {{W{1'b0}}, b};
            glfs_pkg::ALU_SUB: res = {{W{1'b0}}, a} - {{W{1'b0}}, b};
            glfs_pkg::ALU_MUL: res = a * b;
            default:           res = '0;
        endcase
    end

endmodule

// File: hw/rtl/grid_liquid_flow_step.sv
// top level of the grid liquid flow block: cell store, sequencer and shared alu
//
// usage
// - one request beat on the s_ channel: s_tuser selects tick, write or read,
//   s_tdata carries the cell coordinates and the tile and level to write
// - every request gives exactly one result beat on the m_ channel; a read
//   returns the cell's tile and level with m_tuser high, other requests
//   return zeros with m_tuser low
// - a tick sweeps the grid cell by cell, left to right and bottom to top;
//   a cell holding liquid also reads its neighbors below, left and right,
//   moves liquid and writes them back, the longest path being a fall
//   followed by a three-way split; a flag pass then clears every done
//   flag; the single read port of the cell store sets the pace of a tick
// - one request at a time: s_tready is low from acceptance until the
//   result beat has been taken
// - after reset the cell store is cleared one cell per cycle, with s_tready low
// - when the receiver stalls, the result holds on m_tdata and m_tuser
//   and no new request is taken
module grid_liquid_flow_step #(
    parameter int GRID_WIDTH  = glfs_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = glfs_pkg::GRID_HEIGHT_DEF,
    parameter int MAX_LEVEL   = glfs_pkg::MAX_LEVEL_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // col [5:0], row [11:6], tile_kind [13:12], fill_level [18:14]
    input  logic [23:0] s_tdata,
    // func [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_tile [1:0], out_level [6:2]
    output logic [7:0]  m_tdata,
    // is_read_reply [0]
    output logic        m_tuser
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int LW    = $clog2(MAX_LEVEL + 1);
    localparam int SW    = LW + 2;
    // cell word: tile, level, done flag, last flow direction
    localparam int L_LO  = 2;
    localparam int L_HI  = LW + 1;
    localparam int D_BIT = LW + 2;
    localparam int R_LO  = LW + 3;
    localparam int R_HI  = LW + 4;
    localparam int CW    = LW + 5;
    localparam logic [SW-1:0] RECIP3  = SW'((2 ** SW) / glfs_pkg::SPLIT_THREE);
    localparam logic [SW-1:0] THREE   = SW'(glfs_pkg::SPLIT_THREE);
    localparam logic [LW-1:0] MAX_L   = LW'(MAX_LEVEL);
    localparam logic [AW-1:0] ROW_UP  = AW'(2 * GRID_WIDTH - 1);
    localparam logic [AW-1:0] START_A = AW'((GRID_HEIGHT - 1) * GRID_WIDTH);

    glfs_pkg::state_t state_reg, state_next;

    logic [AW:0]     clr_reg, clr_next;
    logic [XW-1:0]   x_reg, x_next;
    logic [YW-1:0]   y_reg, y_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [CW-1:0]   c_word_reg, c_word_next;
    logic [CW-1:0]   b_word_reg, b_word_next;
    logic [CW-1:0]   l_word_reg, l_word_next;
    logic [CW-1:0]   r_word_reg, r_word_next;
    logic [LW-1:0]   own_reg, own_next;
    logic [LW-1:0]   room_reg, room_next;
    logic [LW-1:0]   mv_reg, mv_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic [SW-1:0]   q_reg, q_next;
    logic [SW-1:0]   prod_reg, prod_next;
    logic [SW-1:0]   rem_reg, rem_next;
    logic [AW-1:0]   host_addr_reg, host_addr_next;
    logic            inside_reg, inside_next;
    logic [1:0]      wr_tile_reg, wr_tile_next;
    logic [LW-1:0]   wr_lvl_reg, wr_lvl_next;
    logic [1:0]      m_tile_reg, m_tile_next;
    logic [4:0]      m_level_reg, m_level_next;
    logic            m_read_reg, m_read_next;

    // request fields
    logic [5:0]      in_col;
    logic [5:0]      in_row;
    logic [1:0]      in_kind;
    logic [4:0]      in_fill;
    glfs_pkg::func_t in_func;
    logic            s_beat;

    // cell store ports
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [CW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [CW-1:0]   ram_rdata;
    logic [CW-1:0]   flag_clr_w;

    // shared alu
    glfs_pkg::alu_op_t alu_op;
    logic [SW-1:0]     alu_a;
    logic [SW-1:0]     alu_b;
    logic [2*SW-1:0]   alu_res;

    // neighbor view
    logic [LW-1:0]   c_lvl, b_lvl, l_lvl, r_lvl;
    logic            has_b, has_l, has_r;
    logic            down_w, left_w, right_w, active_w;
    logic [LW+4:0]   rd_lvl_ext;

    assign in_col  = s_tdata[5:0];
    assign in_row  = s_tdata[11:6];
    assign in_kind = s_tdata[13:12];
    assign in_fill = s_tdata[18:14];
    assign in_func = glfs_pkg::func_t'(s_tuser);
    assign s_beat  = s_tvalid && s_tready;

    assign c_lvl = c_word_reg[L_HI:L_LO];
    assign b_lvl = b_word_reg[L_HI:L_LO];
    assign l_lvl = l_word_reg[L_HI:L_LO];
    assign r_lvl = r_word_reg[L_HI:L_LO];

    assign has_b = (y_reg != YW'(GRID_HEIGHT - 1));
    assign has_l = (x_reg != '0);
    assign has_r = (x_reg != XW'(GRID_WIDTH - 1));

    // the cell below takes liquid while it has room
    assign down_w  = has_b && (b_word_reg[1:0] == glfs_pkg::TILE_AIR) && (b_lvl < MAX_L);
    // side neighbors take liquid only when lower than the cell was at the start
    assign left_w  = has_l && (l_word_reg[1:0] == glfs_pkg::TILE_AIR) &&
                     (l_lvl < MAX_L) && (l_lvl < own_reg);
    assign right_w = has_r && (r_word_reg[1:0] == glfs_pkg::TILE_AIR) &&
                     (r_lvl < MAX_L) && (r_lvl < own_reg);
    assign active_w = (ram_rdata[1:0] == glfs_pkg::TILE_AIR) &&
                      (ram_rdata[L_HI:L_LO] != '0) && !ram_rdata[D_BIT];

    assign rd_lvl_ext = {5'b0, ram_rdata[L_HI:L_LO]};

    always_comb begin
        flag_clr_w        = ram_rdata;
        flag_clr_w[D_BIT] = 1'b0;
    end

    glfs_ram #(
        .WIDTH (CW),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    glfs_alu #(
        .W (SW)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            glfs_pkg::ST_CLEAR: begin
                if (clr_reg[AW-1:0] == AW'(CELLS - 1)) begin
                    state_next = glfs_pkg::ST_IDLE;
                end
            end
            glfs_pkg::ST_IDLE: begin
                if (s_beat) begin
                    case (in_func)
                        glfs_pkg::FUNC_TICK:  state_next = glfs_pkg::ST_RD_C;
                        glfs_pkg::FUNC_WRITE: state_next = glfs_pkg::ST_WRITE;
                        glfs_pkg::FUNC_READ:  state_next = glfs_pkg::ST_READ;
                        default:              state_next = glfs_pkg::ST_OUT;
                    endcase
                end
            end
            glfs_pkg::ST_WRITE:    state_next = glfs_pkg::ST_OUT;
            glfs_pkg::ST_READ:     state_next = glfs_pkg::ST_READ_CAP;
            glfs_pkg::ST_READ_CAP: state_next = glfs_pkg::ST_OUT;
            glfs_pkg::ST_OUT: begin
                if (m_tready) begin
                    state_next = glfs_pkg::ST_IDLE;
                end
            end
            glfs_pkg::ST_RD_C: state_next = glfs_pkg::ST_CHK;
            glfs_pkg::ST_CHK: begin
                state_next = active_w ? glfs_pkg::ST_GET_B : glfs_pkg::ST_NEXT;
            end
            glfs_pkg::ST_GET_B: state_next = glfs_pkg::ST_GET_L;
            glfs_pkg::ST_GET_L: state_next = glfs_pkg::ST_GET_R;
            glfs_pkg::ST_GET_R: state_next = glfs_pkg::ST_ROOM;
            glfs_pkg::ST_ROOM: begin
                state_next = down_w ? glfs_pkg::ST_MOVE : glfs_pkg::ST_SIDE;
            end
            glfs_pkg::ST_MOVE:   state_next = glfs_pkg::ST_FALL_B;
            glfs_pkg::ST_FALL_B: state_next = glfs_pkg::ST_FALL_C;
            glfs_pkg::ST_FALL_C: begin
                // all liquid fell: nothing left to share sideways
                state_next = (alu_res[LW-1:0] == '0) ? glfs_pkg::ST_WR_C : glfs_pkg::ST_SIDE;
            end
            glfs_pkg::ST_SIDE: begin
                if (left_w && right_w) begin
                    state_next = glfs_pkg::ST_SUM3;
                end else if (left_w || right_w) begin
                    state_next = glfs_pkg::ST_PAIR;
                end else begin
                    state_next = glfs_pkg::ST_WR_C;
                end
            end
            glfs_pkg::ST_SUM3: state_next = glfs_pkg::ST_DIV;
            glfs_pkg::ST_DIV:  state_next = glfs_pkg::ST_MUL3;
            glfs_pkg::ST_MUL3: state_next = glfs_pkg::ST_REM;
            glfs_pkg::ST_REM:  state_next = glfs_pkg::ST_FIX;
            glfs_pkg::ST_FIX: begin
                state_next = (rem_reg >= THREE) ? glfs_pkg::ST_FIX_Q : glfs_pkg::ST_SPLIT3;
            end
            glfs_pkg::ST_FIX_Q:  state_next = glfs_pkg::ST_SPLIT3;
            glfs_pkg::ST_SPLIT3: state_next = glfs_pkg::ST_WR_C;
            glfs_pkg::ST_PAIR:   state_next = glfs_pkg::ST_WR_C;
            glfs_pkg::ST_WR_C:   state_next = glfs_pkg::ST_WR_B;
            glfs_pkg::ST_WR_B:   state_next = glfs_pkg::ST_WR_L;
            glfs_pkg::ST_WR_L:   state_next = glfs_pkg::ST_WR_R;
            glfs_pkg::ST_WR_R:   state_next = glfs_pkg::ST_NEXT;
            glfs_pkg::ST_NEXT: begin
                if (y_reg == '0 && !has_r) begin
                    state_next = glfs_pkg::ST_FLAGS;
                end else begin
                    state_next = glfs_pkg::ST_RD_C;
                end
            end
            glfs_pkg::ST_FLAGS: begin
                if (clr_reg[AW-1:0] == AW'(CELLS - 1)) begin
                    state_next = glfs_pkg::ST_FLAGS_END;
                end
            end
            glfs_pkg::ST_FLAGS_END: state_next = glfs_pkg::ST_OUT;
            default:                state_next = glfs_pkg::ST_IDLE;
        endcase
    end

    // datapath, store and alu control
    always_comb begin
        clr_next       = clr_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        addr_next      = addr_reg;
        c_word_next    = c_word_reg;
        b_word_next    = b_word_reg;
        l_word_next    = l_word_reg;
        r_word_next    = r_word_reg;
        own_next       = own_reg;
        room_next      = room_reg;
        mv_next        = mv_reg;
        sum_next       = sum_reg;
        q_next         = q_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        host_addr_next = host_addr_reg;
        inside_next    = inside_reg;
        wr_tile_next   = wr_tile_reg;
        wr_lvl_next    = wr_lvl_reg;
        m_tile_next    = m_tile_reg;
        m_level_next   = m_level_reg;
        m_read_next    = m_read_reg;

        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = c_word_reg;
        ram_raddr = addr_reg;

        alu_op = glfs_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;

        case (state_reg)
            glfs_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg[AW-1:0];
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            glfs_pkg::ST_IDLE: begin
                if (s_beat) begin
                    m_tile_next    = '0;
                    m_level_next   = '0;
                    m_read_next    = (in_func == glfs_pkg::FUNC_READ);
                    inside_next    = (32'(in_col) < GRID_WIDTH) && (32'(in_row) < GRID_HEIGHT);
                    host_addr_next = AW'(32'(in_row) * GRID_WIDTH + 32'(in_col));
                    wr_tile_next   = in_kind;
                    wr_lvl_next    = (32'(in_fill) > MAX_LEVEL) ? MAX_L : LW'(in_fill);
                    x_next         = '0;
                    y_next         = YW'(GRID_HEIGHT - 1);
                    addr_next      = START_A;
                    clr_next       = '0;
                end
            end
            glfs_pkg::ST_WRITE: begin
                ram_we    = inside_reg;
                ram_waddr = host_addr_reg;
                ram_wdata = {glfs_pkg::DIR_NONE, 1'b0, wr_lvl_reg, wr_tile_reg};
            end
            glfs_pkg::ST_READ: begin
                ram_raddr = host_addr_reg;
            end
            glfs_pkg::ST_READ_CAP: begin
                if (inside_reg) begin
                    m_tile_next  = ram_rdata[1:0];
                    m_level_next = rd_lvl_ext[4:0];
                end
            end
            glfs_pkg::ST_RD_C: begin
                ram_raddr = addr_reg;
            end
            glfs_pkg::ST_CHK: begin
                c_word_next = ram_rdata;
                own_next    = ram_rdata[L_HI:L_LO];
                ram_raddr   = addr_reg + AW'(GRID_WIDTH);
            end
            glfs_pkg::ST_GET_B: begin
                b_word_next = ram_rdata;
                ram_raddr   = addr_reg - 1'b1;
            end
            glfs_pkg::ST_GET_L: begin
                l_word_next = ram_rdata;
                ram_raddr   = addr_reg + 1'b1;
            end
            glfs_pkg::ST_GET_R: begin
                r_word_next = ram_rdata;
            end
            glfs_pkg::ST_ROOM: begin
                alu_op    = glfs_pkg::ALU_SUB;
                alu_a     = SW'(MAX_L);
                alu_b     = SW'(b_lvl);
                room_next = alu_res[LW-1:0];
            end
            glfs_pkg::ST_MOVE: begin
                alu_op  = glfs_pkg::ALU_SUB;
                alu_a   = SW'(c_lvl);
                alu_b   = SW'(room_reg);
                mv_next = alu_res[2*SW-1] ? c_lvl : room_reg;
            end
            glfs_pkg::ST_FALL_B: begin
                alu_op                  = glfs_pkg::ALU_ADD;
                alu_a                   = SW'(b_lvl);
                alu_b                   = SW'(mv_reg);
                b_word_next[L_HI:L_LO]  = alu_res[LW-1:0];
                b_word_next[D_BIT]      = 1'b1;
                b_word_next[R_HI:R_LO]  = glfs_pkg::DIR_NONE;
            end
            glfs_pkg::ST_FALL_C: begin
                alu_op                  = glfs_pkg::ALU_SUB;
                alu_a                   = SW'(c_lvl);
                alu_b                   = SW'(mv_reg);
                c_word_next[L_HI:L_LO]  = alu_res[LW-1:0];
                c_word_next[D_BIT]      = 1'b1;
            end
            glfs_pkg::ST_SIDE: begin
                alu_op   = glfs_pkg::ALU_ADD;
                alu_a    = SW'(c_lvl);
                alu_b    = left_w ? SW'(l_lvl) : SW'(r_lvl);
                sum_next = alu_res[SW-1:0];
            end
            glfs_pkg::ST_SUM3: begin
                alu_op   = glfs_pkg::ALU_ADD;
                alu_a    = sum_reg;
                alu_b    = SW'(r_lvl);
                sum_next = alu_res[SW-1:0];
            end
            glfs_pkg::ST_DIV: begin
                // reciprocal estimate, at most one short of the true quotient
                alu_op = glfs_pkg::ALU_MUL;
                alu_a  = sum_reg;
                alu_b  = RECIP3;
                q_next = alu_res[2*SW-1:SW];
            end
            glfs_pkg::ST_MUL3: begin
                alu_op    = glfs_pkg::ALU_MUL;
                alu_a     = q_reg;
                alu_b     = THREE;
                prod_next = alu_res[SW-1:0];
            end
            glfs_pkg::ST_REM: begin
                alu_op   = glfs_pkg::ALU_SUB;
                alu_a    = sum_reg;
                alu_b    = prod_reg;
                rem_next = alu_res[SW-1:0];
            end
            glfs_pkg::ST_FIX: begin
                alu_op = glfs_pkg::ALU_SUB;
                alu_a  = rem_reg;
                alu_b  = THREE;
                if (rem_reg >= THREE) begin
                    rem_next = alu_res[SW-1:0];
                end
            end
            glfs_pkg::ST_FIX_Q: begin
                alu_op = glfs_pkg::ALU_ADD;
                alu_a  = q_reg;
                alu_b  = SW'(1);
                q_next = alu_res[SW-1:0];
            end
            glfs_pkg::ST_SPLIT3: begin
                alu_op = glfs_pkg::ALU_ADD;
                alu_a  = q_reg;
                alu_b  = rem_reg;
                c_word_next[L_HI:L_LO] = q_reg[LW-1:0];
                c_word_next[D_BIT]     = 1'b1;
                c_word_next[R_HI:R_LO] = glfs_pkg::DIR_NONE;
                l_word_next[L_HI:L_LO] = q_reg[LW-1:0];
                l_word_next[D_BIT]     = 1'b1;
                r_word_next[L_HI:L_LO] = q_reg[LW-1:0];
                r_word_next[D_BIT]     = 1'b1;
                if (rem_reg == '0) begin
                    l_word_next[R_HI:R_LO] = glfs_pkg::DIR_NONE;
                    r_word_next[R_HI:R_LO] = glfs_pkg::DIR_NONE;
                end else if (c_word_reg[R_HI:R_LO] == glfs_pkg::DIR_LEFT) begin
                    // remainder follows the last flow direction
                    l_word_next[L_HI:L_LO] = alu_res[LW-1:0];
                    l_word_next[R_HI:R_LO] = glfs_pkg::DIR_LEFT;
                end else begin
                    r_word_next[L_HI:L_LO] = alu_res[LW-1:0];
                    r_word_next[R_HI:R_LO] = glfs_pkg::DIR_RIGHT;
                end
            end
            glfs_pkg::ST_PAIR: begin
                // neighbor gets the rounded-up half
                alu_op = glfs_pkg::ALU_SUB;
                alu_a  = sum_reg;
                alu_b  = sum_reg >> 1;
                c_word_next[L_HI:L_LO] = sum_reg[LW:1];
                c_word_next[D_BIT]     = 1'b1;
                if (left_w) begin
                    l_word_next[L_HI:L_LO] = alu_res[LW-1:0];
                    l_word_next[D_BIT]     = 1'b1;
                    l_word_next[R_HI:R_LO] = glfs_pkg::DIR_LEFT;
                end else begin
                    r_word_next[L_HI:L_LO] = alu_res[LW-1:0];
                    r_word_next[D_BIT]     = 1'b1;
                    r_word_next[R_HI:R_LO] = glfs_pkg::DIR_RIGHT;
                end
            end
            glfs_pkg::ST_WR_C: begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = c_word_reg;
            end
            glfs_pkg::ST_WR_B: begin
                ram_we    = has_b;
                ram_waddr = addr_reg + AW'(GRID_WIDTH);
                ram_wdata = b_word_reg;
            end
            glfs_pkg::ST_WR_L: begin
                ram_we    = has_l;
                ram_waddr = addr_reg - 1'b1;
                ram_wdata = l_word_reg;
            end
            glfs_pkg::ST_WR_R: begin
                ram_we    = has_r;
                ram_waddr = addr_reg + 1'b1;
                ram_wdata = r_word_reg;
            end
            glfs_pkg::ST_NEXT: begin
                // left to right within a row, rows bottom to top
                if (has_r) begin
                    x_next    = x_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end else begin
                    x_next    = '0;
                    y_next    = y_reg - 1'b1;
                    addr_next = addr_reg - ROW_UP;
                end
                clr_next = '0;
            end
            glfs_pkg::ST_FLAGS: begin
                // read one cell ahead, write back the previous one with done cleared
                ram_raddr = clr_reg[AW-1:0];
                ram_we    = (clr_reg != '0);
                ram_waddr = clr_reg[AW-1:0] - 1'b1;
                ram_wdata = flag_clr_w;
                clr_next  = clr_reg + 1'b1;
            end
            glfs_pkg::ST_FLAGS_END: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(CELLS - 1);
                ram_wdata = flag_clr_w;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= glfs_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        addr_reg      <= addr_next;
        c_word_reg    <= c_word_next;
        b_word_reg    <= b_word_next;
        l_word_reg    <= l_word_next;
        r_word_reg    <= r_word_next;
        own_reg       <= own_next;
        room_reg      <= room_next;
        mv_reg        <= mv_next;
        sum_reg       <= sum_next;
        q_reg         <= q_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        host_addr_reg <= host_addr_next;
        inside_reg    <= inside_next;
        wr_tile_reg   <= wr_tile_next;
        wr_lvl_reg    <= wr_lvl_next;
        m_tile_reg    <= m_tile_next;
        m_level_reg   <= m_level_next;
        m_read_reg    <= m_read_next;
    end

    assign s_tready = (state_reg == glfs_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == glfs_pkg::ST_OUT);
    assign m_tdata  = {1'b0, m_level_reg, m_tile_reg};
    assign m_tuser  = m_read_reg;

endmodule

// File: hw/rtl/glfs_checker.sv
// port-level checks for the grid liquid flow block, bound to the top level
module glfs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser
);

    // one request in flight: no new beat while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request taken while a result is pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after a request beat");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // only read replies carry cell data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 8'd0))
        else $error("non-read result carries data");

    // store clearing follows reset
    assert property (@(posedge aclk)
        !aresetn |=> (!s_tready && !m_tvalid))
        else $error("block ready right after reset");

endmodule

bind grid_liquid_flow_step glfs_checker u_glfs_checker (.*);
